// ----- design/gpq_pkg.sv -----
package gpq_pkg;

  // width of every coordinate on the result channel
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned COORD_BITS_DEF = 32;

  // flag byte bit positions
  localparam int unsigned FLAG_ON_CURVE = 0;
  localparam int unsigned FLAG_SHORT_X  = 1;
  localparam int unsigned FLAG_SHORT_Y  = 2;
  localparam int unsigned FLAG_SAME_X   = 4;
  localparam int unsigned FLAG_SAME_Y   = 5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,  // waiting for a contour start
    PH_START = 2'd1,  // start point queued
    PH_PIVOT = 2'd2   // start and off-curve pivot queued
  } phase_e;

  // control for one point entering the curve machine
  typedef struct packed {
    logic step;
    logic on_curve;
    logic contour_begin;
  } step_t;

endpackage

// ----- design/gpq_if.sv -----
interface gpq_point_if import gpq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  point_flags;
  logic [15:0] x_data;
  logic [15:0] y_data;
  logic        contour_begin;
  logic        glyph_begin;

  modport source (
    output valid, point_flags, x_data, y_data, contour_begin, glyph_begin,
    input  ready
  );
  modport sink (
    input  valid, point_flags, x_data, y_data, contour_begin, glyph_begin,
    output ready
  );
endinterface

interface gpq_curve_if import gpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] start_x;
  logic signed [OUT_W-1:0] start_y;
  logic signed [OUT_W-1:0] control_x;
  logic signed [OUT_W-1:0] control_y;
  logic signed [OUT_W-1:0] end_x;
  logic signed [OUT_W-1:0] end_y;
  logic                    bad_start;

  modport source (
    output valid, start_x, start_y, control_x, control_y, end_x, end_y, bad_start,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, control_x, control_y, end_x, end_y, bad_start,
    output ready
  );
endinterface

// ----- design/gpq_coord_dec.sv -----
module gpq_coord_dec import gpq_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] prev_i,
  input  logic [15:0]                  data_i,
  input  logic                         short_i,
  input  logic                         same_i,
  output logic signed [COORD_BITS-1:0] coord_o
);

  logic [COORD_BITS-1:0] mag;
  logic [COORD_BITS-1:0] delta;

  assign mag   = {{(COORD_BITS-8){1'b0}}, data_i[7:0]};
  assign delta = {{(COORD_BITS-16){data_i[15]}}, data_i};

  always_comb begin
    if (short_i) begin
      // short: unsigned byte, same flag gives the sign
      coord_o = same_i ? (prev_i + mag) : (prev_i - mag);
    end else if (same_i) begin
      coord_o = prev_i;
    end else begin
      coord_o = prev_i + delta;
    end
  end

endmodule

// ----- design/gpq_midpoint.sv -----
module gpq_midpoint import gpq_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output logic signed [COORD_BITS-1:0] mid_o
);

  logic [COORD_BITS:0] sum;
  logic [COORD_BITS:0] adj;

  // one guard bit; negative odd sums round toward zero
  assign sum   = {a_i[COORD_BITS-1], a_i} + {b_i[COORD_BITS-1], b_i};
  assign adj   = sum + {{COORD_BITS{1'b0}}, sum[COORD_BITS] & sum[0]};
  assign mid_o = adj[COORD_BITS:1];

endmodule

// ----- design/gpq_curve_fsm.sv -----
module gpq_curve_fsm import gpq_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  step_t                        ctl_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  output logic                         emit_o,
  output logic                         bad_o,
  output logic signed [COORD_BITS-1:0] sx_o,
  output logic signed [COORD_BITS-1:0] sy_o,
  output logic signed [COORD_BITS-1:0] cx_o,
  output logic signed [COORD_BITS-1:0] cy_o,
  output logic signed [COORD_BITS-1:0] ex_o,
  output logic signed [COORD_BITS-1:0] ey_o
);

  phase_e phase_q, phase_d, phase_eff;
  logic signed [COORD_BITS-1:0] qs_x_q, qs_x_d, qs_y_q, qs_y_d;
  logic signed [COORD_BITS-1:0] qp_x_q, qp_x_d, qp_y_q, qp_y_d;
  logic signed [COORD_BITS-1:0] mid_ax, mid_ay, mid_x, mid_y;

  assign phase_eff = ctl_i.contour_begin ? PH_IDLE : phase_q;

  // shared midpoint: start-to-point in PH_START, pivot-to-point in PH_PIVOT
  assign mid_ax = (phase_eff == PH_START) ? qs_x_q : qp_x_q;
  assign mid_ay = (phase_eff == PH_START) ? qs_y_q : qp_y_q;

  gpq_midpoint #(.COORD_BITS(COORD_BITS)) u_mid_x (
    .a_i(mid_ax), .b_i(x_i), .mid_o(mid_x)
  );
  gpq_midpoint #(.COORD_BITS(COORD_BITS)) u_mid_y (
    .a_i(mid_ay), .b_i(y_i), .mid_o(mid_y)
  );

  // next state
  always_comb begin
    phase_d = phase_q;
    qs_x_d  = qs_x_q;
    qs_y_d  = qs_y_q;
    qp_x_d  = qp_x_q;
    qp_y_d  = qp_y_q;
    if (ctl_i.step) begin
      case (phase_eff)
        PH_START: begin
          if (ctl_i.on_curve) begin
            qs_x_d  = x_i;
            qs_y_d  = y_i;
            phase_d = PH_START;
          end else begin
            qp_x_d  = x_i;
            qp_y_d  = y_i;
            phase_d = PH_PIVOT;
          end
        end
        PH_PIVOT: begin
          if (ctl_i.on_curve) begin
            qs_x_d  = x_i;
            qs_y_d  = y_i;
            phase_d = PH_START;
          end else begin
            qs_x_d  = mid_x;
            qs_y_d  = mid_y;
            qp_x_d  = x_i;
            qp_y_d  = y_i;
            phase_d = PH_PIVOT;
          end
        end
        default: begin
          if (ctl_i.on_curve) begin
            qs_x_d  = x_i;
            qs_y_d  = y_i;
            phase_d = PH_START;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

  // result for this point
  always_comb begin
    emit_o = 1'b0;
    bad_o  = 1'b0;
    sx_o   = '0;
    sy_o   = '0;
    cx_o   = '0;
    cy_o   = '0;
    ex_o   = '0;
    ey_o   = '0;
    case (phase_eff)
      PH_START: begin
        if (ctl_i.on_curve) begin
          emit_o = 1'b1;
          sx_o   = qs_x_q;
          sy_o   = qs_y_q;
          cx_o   = mid_x;
          cy_o   = mid_y;
          ex_o   = x_i;
          ey_o   = y_i;
        end
      end
      PH_PIVOT: begin
        emit_o = 1'b1;
        sx_o   = qs_x_q;
        sy_o   = qs_y_q;
        cx_o   = qp_x_q;
        cy_o   = qp_y_q;
        ex_o   = ctl_i.on_curve ? x_i : mid_x;
        ey_o   = ctl_i.on_curve ? y_i : mid_y;
      end
      default: begin
        if (!ctl_i.on_curve) begin
          emit_o = 1'b1;
          bad_o  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      qs_x_q  <= '0;
      qs_y_q  <= '0;
      qp_x_q  <= '0;
      qp_y_q  <= '0;
    end else begin
      phase_q <= phase_d;
      qs_x_q  <= qs_x_d;
      qs_y_q  <= qs_y_d;
      qp_x_q  <= qp_x_d;
      qp_y_q  <= qp_y_d;
    end
  end

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_o |-> (sx_o == '0) && (sy_o == '0) && (cx_o == '0) && (cy_o == '0)
              && (ex_o == '0) && (ey_o == '0))
    else $error("bad start result carries coordinates");

  a_off_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && ctl_i.contour_begin && !ctl_i.on_curve |=> phase_q == PH_IDLE)
    else $error("off-curve contour start left machine busy");

  a_pivot_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && (phase_eff == PH_PIVOT) |-> emit_o && !bad_o)
    else $error("pivot phase point gave no curve");

endmodule

// ----- design/glyph_points_to_quadratic_curves_unit.sv -----
// Glyph point to quadratic curve unit. One glyph point (flag byte, raw x/y
// data, contour and glyph start marks) is taken per item on point_i, with
// repeat flags already expanded. The x/y deltas are decoded and summed into
// COORD_BITS-wide absolute coordinates that wrap at that width and restart
// from zero on glyph_begin. An on/off-curve machine turns the points into
// quadratic curves on curve_o; implied on-curve points are midpoints rounded
// toward zero, contours are not closed, and an off-curve contour start gives
// one item with bad_start set and all coordinates zero. A point gives zero or
// one curve. Rate: one point per cycle while curve_o is ready; a point
// waits in the input register, its curve in the result register. Between
// the two sit the delta adder and the midpoint adder, which set the
// clock figure. Coordinates leave as the low 32 bits of the COORD_BITS value,
// sign-extended when COORD_BITS is below 32. No clearing pass after reset.
module glyph_points_to_quadratic_curves_unit import gpq_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpq_point_if.sink   point_i,
  gpq_curve_if.source curve_o
);

  // input register
  logic        stage_valid_q;
  logic [7:0]  flags_q;
  logic [15:0] x_data_q, y_data_q;
  logic        contour_begin_q, glyph_begin_q;

  // previous absolute coordinates
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] base_x, base_y, new_x, new_y;

  // curve machine result
  step_t                        ctl;
  logic                         emit, bad;
  logic signed [COORD_BITS-1:0] sx, sy, cx, cy, ex, ey;

  // result register
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] sx_q, sy_q, cx_q, cy_q, ex_q, ey_q;
  logic                    bad_q;

  logic step;

  // stage item moves on whenever the result register has room
  assign step          = stage_valid_q && (!out_valid_q || curve_o.ready);
  assign point_i.ready = !stage_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (point_i.ready) begin
      stage_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_i.valid && point_i.ready) begin
      flags_q         <= point_i.point_flags;
      x_data_q        <= point_i.x_data;
      y_data_q        <= point_i.y_data;
      contour_begin_q <= point_i.contour_begin;
      glyph_begin_q   <= point_i.glyph_begin;
    end
  end

  assign base_x = glyph_begin_q ? '0 : prev_x_q;
  assign base_y = glyph_begin_q ? '0 : prev_y_q;

  gpq_coord_dec #(.COORD_BITS(COORD_BITS)) u_dec_x (
    .prev_i (base_x),
    .data_i (x_data_q),
    .short_i(flags_q[FLAG_SHORT_X]),
    .same_i (flags_q[FLAG_SAME_X]),
    .coord_o(new_x)
  );

  gpq_coord_dec #(.COORD_BITS(COORD_BITS)) u_dec_y (
    .prev_i (base_y),
    .data_i (y_data_q),
    .short_i(flags_q[FLAG_SHORT_Y]),
    .same_i (flags_q[FLAG_SAME_Y]),
    .coord_o(new_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (step) begin
      prev_x_q <= new_x;
      prev_y_q <= new_y;
    end
  end

  assign ctl.step          = step;
  assign ctl.on_curve      = flags_q[FLAG_ON_CURVE];
  assign ctl.contour_begin = contour_begin_q;

  gpq_curve_fsm #(.COORD_BITS(COORD_BITS)) u_fsm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .x_i   (new_x),
    .y_i   (new_y),
    .emit_o(emit),
    .bad_o (bad),
    .sx_o  (sx),
    .sy_o  (sy),
    .cx_o  (cx),
    .cy_o  (cy),
    .ex_o  (ex),
    .ey_o  (ey)
  );

  // result register; a new curve may load in the cycle the old one leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (curve_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      sx_q  <= OUT_W'(sx);
      sy_q  <= OUT_W'(sy);
      cx_q  <= OUT_W'(cx);
      cy_q  <= OUT_W'(cy);
      ex_q  <= OUT_W'(ex);
      ey_q  <= OUT_W'(ey);
      bad_q <= bad;
    end
  end

  assign curve_o.valid     = out_valid_q;
  assign curve_o.start_x   = sx_q;
  assign curve_o.start_y   = sy_q;
  assign curve_o.control_x = cx_q;
  assign curve_o.control_y = cy_q;
  assign curve_o.end_x     = ex_q;
  assign curve_o.end_y     = ey_q;
  assign curve_o.bad_start = bad_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !curve_o.ready |=> out_valid_q)
    else $error("pending curve dropped");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && out_valid_q && !curve_o.ready |=> stage_valid_q)
    else $error("stalled point lost");

  a_glyph_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && glyph_begin_q && !flags_q[FLAG_SHORT_X] && flags_q[FLAG_SAME_X]
    |=> prev_x_q == '0)
    else $error("glyph start did not clear x");

endmodule

// ----- dv/tb.sv -----
module tb;
  import gpq_pkg::*;

  // Quiet cycles (nothing accepted on either channel) before the run is declared hung.
  // A correct run never comes close: gaps are short and random.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Settle time after the last curve owed, so a stray curve can still show up.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  // flag masks built from the package bit positions
  localparam logic [7:0] F_ON      = 8'd1 << FLAG_ON_CURVE;
  localparam logic [7:0] F_SHORT_X = 8'd1 << FLAG_SHORT_X;
  localparam logic [7:0] F_SHORT_Y = 8'd1 << FLAG_SHORT_Y;
  localparam logic [7:0] F_SAME_X  = 8'd1 << FLAG_SAME_X;
  localparam logic [7:0] F_SAME_Y  = 8'd1 << FLAG_SAME_Y;
  // bits the block must ignore
  localparam logic [7:0] F_UNUSED  = 8'hC8;

  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
    logic                    bad;
  } curve_t;

  logic clk;
  logic rst_n;

  gpq_point_if point_ch ();
  gpq_curve_if curve_ch ();

  glyph_points_to_quadratic_curves_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .point_i (point_ch),
    .curve_o (curve_ch)
  );

  // idle percentages for the sender and the receiver
  int unsigned src_idle_pct = 34;
  int unsigned snk_idle_pct = 54;

  int unsigned points_sent    = 0;
  int unsigned stall_cycles   = 0;
  int unsigned mismatch_count = 0;

  // curves the outline tracker says are still owed by the block
  curve_t curves_due[$];
  curve_t got_curve;
  curve_t want_curve;

  // Outline tracker state: a private copy of the block's state.
  phase_e                  node_ph  = PH_IDLE;
  logic signed [OUT_W-1:0] cur_x    = '0;
  logic signed [OUT_W-1:0] cur_y    = '0;
  logic signed [OUT_W-1:0] anchor_x = '0;
  logic signed [OUT_W-1:0] anchor_y = '0;
  logic signed [OUT_W-1:0] pivot_x  = '0;
  logic signed [OUT_W-1:0] pivot_y  = '0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Outline tracker
  // ---------------------------------------------------------------------------

  // Decode one axis delta and add it to the running coordinate.
  // Short form: unsigned low byte, sign from the same/positive flag.
  // Long form: signed 16-bit delta, or no change when the same flag is set.
  function automatic logic signed [OUT_W-1:0] advance_coord(
    input logic signed [OUT_W-1:0] prev,
    input logic [15:0]             data,
    input logic                    is_short,
    input logic                    same
  );
    logic signed [OUT_W-1:0] delta;
    if (is_short) begin
      delta = {{(OUT_W-8){1'b0}}, data[7:0]};
      return same ? prev + delta : prev - delta;
    end
    if (same) return prev;
    delta = {{(OUT_W-16){data[15]}}, data};
    return prev + delta;
  endfunction

  // (a + b) / 2 rounded toward zero; one extra bit keeps the sum exact.
  function automatic logic signed [OUT_W-1:0] toward_zero_mid(
    input logic signed [OUT_W-1:0] a,
    input logic signed [OUT_W-1:0] b
  );
    logic [OUT_W:0] sum;
    sum = {a[OUT_W-1], a} + {b[OUT_W-1], b};
    // negative and odd: bump up so the shift truncates toward zero
    if (sum[OUT_W] && sum[0]) sum = sum + 1'b1;
    return sum[OUT_W:1];
  endfunction

  // Advance the tracker by one accepted point; queue the curve it owes, if any.
  task automatic trace_outline(
    input logic [7:0]  flags,
    input logic [15:0] xd,
    input logic [15:0] yd,
    input logic        cb,
    input logic        gb
  );
    logic                    on;
    logic signed [OUT_W-1:0] mx;
    logic signed [OUT_W-1:0] my;
    on = flags[FLAG_ON_CURVE];
    if (gb) begin
      cur_x = '0;
      cur_y = '0;
    end
    if (cb) node_ph = PH_IDLE;
    cur_x = advance_coord(cur_x, xd, flags[FLAG_SHORT_X], flags[FLAG_SAME_X]);
    cur_y = advance_coord(cur_y, yd, flags[FLAG_SHORT_Y], flags[FLAG_SAME_Y]);

    case (node_ph)
      PH_START: begin
        if (on) begin
          // on after on: straight segment, control is the midpoint
          curves_due.push_back('{anchor_x, anchor_y,
                                 toward_zero_mid(anchor_x, cur_x),
                                 toward_zero_mid(anchor_y, cur_y),
                                 cur_x, cur_y, 1'b0});
          anchor_x = cur_x;
          anchor_y = cur_y;
        end else begin
          pivot_x = cur_x;
          pivot_y = cur_y;
          node_ph = PH_PIVOT;
        end
      end
      PH_PIVOT: begin
        if (on) begin
          curves_due.push_back('{anchor_x, anchor_y, pivot_x, pivot_y,
                                 cur_x, cur_y, 1'b0});
          anchor_x = cur_x;
          anchor_y = cur_y;
          node_ph  = PH_START;
        end else begin
          // two off points in a row: implied on point halfway between
          mx = toward_zero_mid(pivot_x, cur_x);
          my = toward_zero_mid(pivot_y, cur_y);
          curves_due.push_back('{anchor_x, anchor_y, pivot_x, pivot_y,
                                 mx, my, 1'b0});
          anchor_x = mx;
          anchor_y = my;
          pivot_x  = cur_x;
          pivot_y  = cur_y;
        end
      end
      default: begin
        if (on) begin
          anchor_x = cur_x;
          anchor_y = cur_y;
          node_ph  = PH_START;
        end else begin
          // contour opens off-curve: flagged, all coordinates zero
          curves_due.push_back('{'0, '0, '0, '0, '0, '0, 1'b1});
          node_ph = PH_IDLE;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(
    input string                   name,
    input logic signed [OUT_W-1:0] want,
    input logic signed [OUT_W-1:0] got
  );
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("curve mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // One process sees both channels at each rising edge: input points feed the
  // tracker first, then any curve leaving the block is checked against the
  // oldest one owed. Keeping both in one process avoids any ordering question.
  always @(posedge clk) begin
    if (rst_n) begin
      if (point_ch.valid && point_ch.ready)
        trace_outline(point_ch.point_flags, point_ch.x_data, point_ch.y_data,
                      point_ch.contour_begin, point_ch.glyph_begin);

      if (curve_ch.valid && curve_ch.ready) begin
        got_curve = '{curve_ch.start_x, curve_ch.start_y, curve_ch.control_x,
                      curve_ch.control_y, curve_ch.end_x, curve_ch.end_y,
                      curve_ch.bad_start};
        if (curves_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected curve: start (%0d,%0d) ctrl (%0d,%0d) end (%0d,%0d) bad %0b",
                     got_curve.sx, got_curve.sy, got_curve.cx, got_curve.cy,
                     got_curve.ex, got_curve.ey, got_curve.bad);
        end else begin
          want_curve = curves_due.pop_front();
          check_field("start_x",   want_curve.sx, got_curve.sx);
          check_field("start_y",   want_curve.sy, got_curve.sy);
          check_field("control_x", want_curve.cx, got_curve.cx);
          check_field("control_y", want_curve.cy, got_curve.cy);
          check_field("end_x",     want_curve.ex, got_curve.ex);
          check_field("end_y",     want_curve.ey, got_curve.ey);
          check_field("bad_start", {{(OUT_W-1){1'b0}}, want_curve.bad},
                      {{(OUT_W-1){1'b0}}, got_curve.bad});
        end
      end

      // watchdog bookkeeping: any handshake counts as progress
      if ((point_ch.valid && point_ch.ready) || (curve_ch.valid && curve_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: ready decided fresh every falling edge.
  always @(negedge clk) begin
    curve_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: a hung block ends the run.
  initial begin
    do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $display("[glyph_points_to_quadratic_curves_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one point. Entered and left at a falling edge. Valid stays high from
  // item to item unless a random gap drops it, so it is never lowered and
  // raised in the same step.
  task automatic send_point(
    input logic [7:0]  flags,
    input logic [15:0] xd,
    input logic [15:0] yd,
    input logic        cb,
    input logic        gb
  );
    while ($urandom_range(99) < src_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(negedge clk);
    end
    point_ch.valid         <= 1'b1;
    point_ch.point_flags   <= flags;
    point_ch.x_data        <= xd;
    point_ch.y_data        <= yd;
    point_ch.contour_begin <= cb;
    point_ch.glyph_begin   <= gb;
    do @(posedge clk); while (!point_ch.ready);
    points_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until the block has delivered every curve owed.
  task automatic hold_until_drained();
    point_ch.valid <= 1'b0;
    while (curves_due.size() != 0) @(negedge clk);
  endtask

  // Field extremes: largest long deltas both ways, short magnitude 255 with
  // junk in the high byte, every flag bit set, same-as-before on long form.
  task automatic test_field_extremes();
    send_point(F_ON,                                16'h7FFF, 16'h8000, 1'b1, 1'b1);
    send_point(F_ON | F_SHORT_X | F_SHORT_Y | F_SAME_X,
                                                    16'hABFF, 16'h54FF, 1'b0, 1'b0);
    send_point(8'hFF,                               16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_point(F_ON | F_SAME_X | F_SAME_Y,          16'hFFFF, 16'h8000, 1'b0, 1'b0);
    send_point(8'h00,                               16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_point(F_UNUSED,                            16'h0001, 16'hFFFF, 1'b0, 1'b0);
    send_point(F_ON | F_UNUSED,                     16'h0000, 16'h0000, 1'b0, 1'b0);
  endtask

  // Every transition out of the start and pivot phases, with odd negative sums
  // so the midpoints have to round toward zero rather than down.
  task automatic test_curve_phases();
    send_point(F_ON,                    16'hFFFD, 16'hFFFB, 1'b1, 1'b1);
    send_point(F_SHORT_X | F_SHORT_Y,   16'h0002, 16'h0004, 1'b0, 1'b0);
    send_point(8'h00,                   16'h0001, 16'h0002, 1'b0, 1'b0);
    send_point(F_ON,                    16'hFFFE, 16'h0003, 1'b0, 1'b0);
    send_point(F_ON | F_SHORT_X,        16'h0007, 16'h0001, 1'b0, 1'b0);
    send_point(F_SHORT_Y | F_SAME_Y,    16'h0100, 16'h0080, 1'b0, 1'b0);
    send_point(F_ON | F_SAME_X,         16'h1234, 16'hF000, 1'b0, 1'b0);
  endtask

  // Off-curve contour starts from every phase, a start without a contour mark,
  // and coordinates that keep accumulating through flagged points.
  task automatic test_bad_start();
    send_point(8'h00,       16'h0005, 16'h0003, 1'b1, 1'b1);
    send_point(F_SHORT_X,   16'h0009, 16'h0001, 1'b0, 1'b0);
    send_point(F_ON,        16'h0001, 16'h0001, 1'b0, 1'b0);
    send_point(8'h00,       16'h0010, 16'h0010, 1'b0, 1'b0);
    send_point(8'h00,       16'h0002, 16'h0002, 1'b1, 1'b0);
    send_point(F_ON,        16'h0003, 16'h0003, 1'b1, 1'b0);
    send_point(8'h00,       16'h0004, 16'h0004, 1'b1, 1'b0);
  endtask

  // Mostly well-formed glyphs (marked contours, on-curve starts, random mix of
  // on/off points and random data), with bursts of raw noise in between.
  task automatic test_random_outlines(
    input int unsigned goal,
    input int unsigned src_pct,
    input int unsigned snk_pct
  );
    int unsigned stop_at;
    int          contours;
    int          len;
    logic [7:0]  flags;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = points_sent + goal;
    while (points_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 5))
          send_point(8'($urandom_range(255)), 16'($urandom), 16'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        contours = $urandom_range(1, 4);
        for (int c = 0; c < contours; c++) begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            flags = 8'($urandom_range(255));
            // starts are nearly always on-curve; later points are a coin toss
            flags[FLAG_ON_CURVE] = (i == 0) ? ($urandom_range(99) < 93)
                                            : ($urandom_range(99) < 55);
            send_point(flags, 16'($urandom), 16'($urandom),
                       (i == 0), (c == 0 && i == 0));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                  = 1'b0;
    point_ch.valid         = 1'b0;
    point_ch.point_flags   = '0;
    point_ch.x_data        = '0;
    point_ch.y_data        = '0;
    point_ch.contour_begin = 1'b0;
    point_ch.glyph_begin   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_curve_phases();
    test_bad_start();
    hold_until_drained();

    test_random_outlines(510, 34, 54);
    hold_until_drained();
    test_random_outlines(510, 54, 34);
    hold_until_drained();
    test_random_outlines(510, 0, 0);
    hold_until_drained();

    // any stray curve after the last one owed shows up as unexpected
    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatch_count += curves_due.size();

    if (mismatch_count == 0)
      $display("[glyph_points_to_quadratic_curves_unit] OK");
    else
      $display("[glyph_points_to_quadratic_curves_unit] ERROR");
    $finish;
  end

endmodule
